// ----- rtl/json_tick_field_decoder_top_macros.svh -----
// Assertion helpers for the tick field decoder.
`ifndef JSON_TICK_FIELD_DECODER_TOP_MACROS_SVH
`define JSON_TICK_FIELD_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define JTFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define JTFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JTFD_ASSERT(label, clk, rst_n, prop, msg)
`define JTFD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/jtfd_pkg.sv -----
`timescale 1ns / 1ps
package jtfd_pkg;

    localparam int KEY_NUM = 4;

    // largest magnitude that may still take another digit without overflow
    localparam logic [63:0] MAG_LIM = 64'd922337203685477580;
    localparam logic [63:0] MAG_TOP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [6:0] {
        PH_SEARCH = 7'b0000001,
        PH_SEP    = 7'b0000010,
        PH_WS     = 7'b0000100,
        PH_SIGN   = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_FAILED = 7'b1000000
    } t_phase;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       text;
        logic       is_digit;
        logic       is_ws;
        logic       is_sep;
        logic       is_sign;
        logic       is_minus;
        logic       is_quote;
        logic       last;
    } t_cls;

    // per-key state captured at the end of a message
    typedef struct packed {
        logic [KEY_NUM-1:0]       ok;
        logic [KEY_NUM-1:0]       neg;
        logic [KEY_NUM-1:0]       ovf;
        logic [KEY_NUM-1:0][63:0] mag;
    } t_snap;

    function automatic logic [3:0] key_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            2'd0:    len = 4'd11;
            2'd1:    len = 4'd7;
            2'd2:    len = 4'd8;
            default: len = 4'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] ch;
        ch = CH_QUOTE;
        case (k)
            2'd0: begin
                case (p)
                    4'd1:    ch = "s";
                    4'd2:    ch = "y";
                    4'd3:    ch = "m";
                    4'd4:    ch = "b";
                    4'd5:    ch = "o";
                    4'd6:    ch = "l";
                    4'd7:    ch = "_";
                    4'd8:    ch = "i";
                    4'd9:    ch = "d";
                    default: ch = CH_QUOTE;
                endcase
            end
            2'd1: begin
                case (p)
                    4'd1:    ch = "p";
                    4'd2:    ch = "r";
                    4'd3:    ch = "i";
                    4'd4:    ch = "c";
                    4'd5:    ch = "e";
                    default: ch = CH_QUOTE;
                endcase
            end
            2'd2: begin
                case (p)
                    4'd1:    ch = "v";
                    4'd2:    ch = "o";
                    4'd3:    ch = "l";
                    4'd4:    ch = "u";
                    4'd5:    ch = "m";
                    4'd6:    ch = "e";
                    default: ch = CH_QUOTE;
                endcase
            end
            default: begin
                case (p)
                    4'd1:    ch = "t";
                    4'd2:    ch = "s";
                    default: ch = CH_QUOTE;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/jtfd_fifo.sv -----
`timescale 1ns / 1ps
`include "json_tick_field_decoder_top_macros.svh"
module jtfd_fifo
    import jtfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cls i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cls o_rdata,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (i_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    `JTFD_ASSERT_NEVER(a_fifo_overfill, i_clk, i_rst_n, r_count > CW'(DEPTH), "fifo count beyond depth")
    `JTFD_ASSERT(a_fifo_count_up, i_clk, i_rst_n, (i_wr && !i_rd) |=> (r_count == $past(r_count) + CW'(1)), "fifo count did not advance on write")

endmodule

// ----- rtl/jtfd_front.sv -----
`timescale 1ns / 1ps
module jtfd_front
    import jtfd_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_cls       o_cls
);
    localparam int CW = $clog2(MAX_MESSAGE_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic          r_ended, n_ended;
    logic          w_open;
    logic          w_digit;

    // text window still open: no NUL seen and room left under the byte limit
    assign w_open  = !r_ended && (r_count < CW'(MAX_MESSAGE_BYTES - 1));
    assign w_digit = (i_data_byte >= "0") && (i_data_byte <= "9");

    always_comb begin
        o_cls.data     = i_data_byte;
        o_cls.text     = w_open && (i_data_byte != CH_NUL);
        o_cls.is_digit = w_digit;
        o_cls.is_ws    = (i_data_byte == CH_SPACE) ||
                         ((i_data_byte >= 8'h09) && (i_data_byte <= 8'h0D));
        o_cls.is_sep   = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB) ||
                         (i_data_byte == CH_COLON);
        o_cls.is_sign  = (i_data_byte == CH_PLUS) || (i_data_byte == CH_MINUS);
        o_cls.is_minus = (i_data_byte == CH_MINUS);
        o_cls.is_quote = (i_data_byte == CH_QUOTE);
        o_cls.last     = i_last_byte;
    end

    always_comb begin
        n_count = r_count;
        n_ended = r_ended;
        if (i_accept) begin
            if (i_last_byte) begin
                n_count = '0;
                n_ended = 1'b0;
            end else if (w_open) begin
                if (i_data_byte == CH_NUL) begin
                    n_ended = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ended <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ended <= n_ended;
        end
    end

endmodule

// ----- rtl/jtfd_back.sv -----
`timescale 1ns / 1ps
`include "json_tick_field_decoder_top_macros.svh"
module jtfd_back
    import jtfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fifo_empty,
    input  t_cls  i_head,
    output logic  o_fifo_rd,
    output logic  o_snap_valid,
    output t_snap o_snap,
    input  logic  i_snap_ready
);
    logic w_msg_end;

    wire logic [KEY_NUM-1:0]       w_ok;
    wire logic [KEY_NUM-1:0]       w_neg;
    wire logic [KEY_NUM-1:0]       w_ovf;
    wire logic [KEY_NUM-1:0][63:0] w_mag;

    // a last byte waits here until the result stage has room
    assign o_fifo_rd    = !i_fifo_empty && (!i_head.last || i_snap_ready);
    assign w_msg_end    = o_fifo_rd && i_head.last;
    assign o_snap_valid = w_msg_end;

    assign o_snap.ok  = w_ok;
    assign o_snap.neg = w_neg;
    assign o_snap.ovf = w_ovf;
    assign o_snap.mag = w_mag;

    for (genvar k = 0; k < KEY_NUM; k++) begin : g_key
        localparam logic [3:0] KEY_LEN = key_len(2'(k));

        logic [3:0]  r_prog, n_prog;
        t_phase      r_phase, n_phase;
        logic [63:0] r_mag, n_mag;
        logic        r_neg, n_neg;
        logic        r_ovf, n_ovf;
        logic        w_take_ws;
        logic        w_add;

        always_comb begin
            n_prog = r_prog;
            n_phase = r_phase;
            n_mag = r_mag;
            n_neg = r_neg;
            n_ovf = r_ovf;
            w_take_ws = 1'b0;
            w_add = 1'b0;
            if (i_head.text) begin
                case (r_phase)
                    PH_SEARCH: begin
                        if ((r_prog < KEY_LEN) && (i_head.data == key_char(2'(k), r_prog))) begin
                            n_prog = r_prog + 4'd1;
                        end else begin
                            // keys carry quotes only at their ends
                            n_prog = i_head.is_quote ? 4'd1 : 4'd0;
                        end
                        if (n_prog == KEY_LEN) begin
                            n_phase = PH_SEP;
                        end
                    end
                    PH_SEP: begin
                        if (!i_head.is_sep) begin
                            w_take_ws = 1'b1;
                        end
                    end
                    PH_WS: begin
                        w_take_ws = 1'b1;
                    end
                    PH_SIGN: begin
                        if (i_head.is_digit) begin
                            w_add = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_FAILED;
                        end
                    end
                    PH_DIGITS: begin
                        if (i_head.is_digit) begin
                            w_add = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_take_ws) begin
                    if (i_head.is_ws) begin
                        n_phase = PH_WS;
                    end else if (i_head.is_sign) begin
                        n_neg = i_head.is_minus;
                        n_phase = PH_SIGN;
                    end else if (i_head.is_digit) begin
                        w_add = 1'b1;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_FAILED;
                    end
                end
                if (w_add && !r_ovf) begin
                    if ((r_mag > MAG_LIM) || ((r_mag == MAG_LIM) && (i_head.data[3:0] == 4'd9))) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = (r_mag << 3) + (r_mag << 1) + {60'd0, i_head.data[3:0]};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || w_msg_end) begin
                r_prog <= '0;
                r_phase <= PH_SEARCH;
                r_mag <= '0;
                r_neg <= 1'b0;
                r_ovf <= 1'b0;
            end else if (o_fifo_rd) begin
                r_prog <= n_prog;
                r_phase <= n_phase;
                r_mag <= n_mag;
                r_neg <= n_neg;
                r_ovf <= n_ovf;
            end
        end

        assign w_ok[k]  = (n_phase == PH_DIGITS) || (n_phase == PH_DONE);
        assign w_neg[k] = n_neg;
        assign w_ovf[k] = n_ovf;
        assign w_mag[k] = n_mag;

        `JTFD_ASSERT_NEVER(a_search_prog, i_clk, i_rst_n, (r_phase == PH_SEARCH) && (r_prog >= KEY_LEN), "key progress reached its length while searching")
        `JTFD_ASSERT(a_msg_restart, i_clk, i_rst_n, w_msg_end |=> ((r_phase == PH_SEARCH) && (r_prog == 4'd0)), "key state not cleared after message end")
    end

endmodule

// ----- rtl/jtfd_out.sv -----
`timescale 1ns / 1ps
`include "json_tick_field_decoder_top_macros.svh"
module jtfd_out
    import jtfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_valid,
    input  t_snap       i_snap,
    output logic        o_snap_ready,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_decoded_ok,
    output logic [KEY_NUM-1:0][63:0] o_val
);
    t_snap r_fin;
    logic  r_fin_valid;
    logic  w_fin_adv;
    logic  w_ok;

    logic                     r_out_valid;
    logic                     r_out_ok;
    logic [KEY_NUM-1:0][63:0] r_out_val;
    logic [KEY_NUM-1:0][63:0] n_out_val;

    function automatic logic [63:0] key_value(input logic ok, input logic neg,
                                              input logic ovf, input logic [63:0] mag);
        logic [63:0] v;
        if (!ok) begin
            v = '0;
        end else if (neg) begin
            v = ovf ? MAG_TOP : (64'd0 - mag);
        end else if (ovf || mag[63]) begin
            v = POS_MAX;
        end else begin
            v = mag;
        end
        return v;
    endfunction

    assign w_fin_adv    = r_fin_valid && (!r_out_valid || i_pop);
    assign o_snap_ready = !r_fin_valid || w_fin_adv;
    assign w_ok         = r_fin.ok[0] && r_fin.ok[1] && r_fin.ok[2];

    always_comb begin
        for (int k = 0; k < KEY_NUM; k++) begin
            n_out_val[k] = w_ok ?
                key_value(r_fin.ok[k], r_fin.neg[k], r_fin.ovf[k], r_fin.mag[k]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_snap_valid) begin
                r_fin_valid <= 1'b1;
            end else if (w_fin_adv) begin
                r_fin_valid <= 1'b0;
            end
            if (w_fin_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid) begin
            r_fin <= i_snap;
        end
        if (w_fin_adv) begin
            r_out_ok <= w_ok;
            r_out_val <= n_out_val;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_decoded_ok = r_out_ok;
    assign o_val        = r_out_val;

    `JTFD_ASSERT(a_fail_zero, i_clk, i_rst_n, (r_out_valid && !r_out_ok) |-> (r_out_val == '0), "failed decode with nonzero fields")
    `JTFD_ASSERT(a_fin_moves, i_clk, i_rst_n, (r_fin_valid && !r_out_valid) |=> r_out_valid, "finished message did not reach the output register")

endmodule

// ----- rtl/json_tick_field_decoder_top.sv -----
`timescale 1ns / 1ps
// Tick field decoder: takes one message text byte per cycle (push/full) and,
// for each byte marked last, returns one result (empty/pop) with decoded_ok and
// the instrument id, price, volume and timestamp values. A classifier front end
// marks every byte and tracks the NUL / length limit, a 4-entry queue decouples
// it from the key matchers, which consume one byte per cycle, so the sustained
// rate is one byte per cycle while no last byte waits for result room. With the
// queue otherwise empty, a last byte is read by the matchers, their state goes
// to the finished-message register and then to the value formatting register on
// the output. Two finished messages can wait for pop; a further last byte holds
// in the queue until one is taken, and push sees full at 4 queue entries.
module json_tick_field_decoder_top
    import jtfd_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic               o_decoded_ok,
    output logic signed [63:0] o_instr_id,
    output logic signed [63:0] o_price,
    output logic signed [63:0] o_volume,
    output logic signed [63:0] o_timestamp
);
    logic  w_accept;
    t_cls  w_cls;
    t_cls  w_head;
    logic  w_fifo_rd;
    logic  w_fifo_empty;
    logic  w_snap_valid;
    logic  w_snap_ready;
    t_snap w_snap;
    logic [KEY_NUM-1:0][63:0] w_val;

    assign w_accept = push && !full;

    jtfd_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_cls      (w_cls)
    );

    jtfd_fifo #(
        .DEPTH(4)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_accept),
        .i_wdata(w_cls),
        .o_full (full),
        .i_rd   (w_fifo_rd),
        .o_rdata(w_head),
        .o_empty(w_fifo_empty)
    );

    jtfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_empty(w_fifo_empty),
        .i_head      (w_head),
        .o_fifo_rd   (w_fifo_rd),
        .o_snap_valid(w_snap_valid),
        .o_snap      (w_snap),
        .i_snap_ready(w_snap_ready)
    );

    jtfd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_valid(w_snap_valid),
        .i_snap      (w_snap),
        .o_snap_ready(w_snap_ready),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_decoded_ok(o_decoded_ok),
        .o_val       (w_val)
    );

    assign o_instr_id  = signed'(w_val[0]);
    assign o_price     = signed'(w_val[1]);
    assign o_volume    = signed'(w_val[2]);
    assign o_timestamp = signed'(w_val[3]);

endmodule
